// ===== src/ajb_pkg.sv =====
`default_nettype none
package ajb_pkg;

  localparam int CAPACITY_DEFAULT = 1024;

  localparam int FUNC_W   = 2;
  localparam int BYTE_W   = 8;
  localparam int SAMPLE_W = 16;
  localparam int FILL_W   = 11;
  localparam int THR_W    = 11;
  localparam int SHIFT_W  = 4;
  localparam int CFG_W    = 11;
  localparam int CFG_IDX_W = 1;
  localparam int SCALE_W  = 24;

  localparam logic [THR_W-1:0]   THR_RESET   = 11'd256;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd7;

  localparam logic signed [SCALE_W-1:0] SAT_MAX = 24'sd32767;
  localparam logic signed [SCALE_W-1:0] SAT_MIN = -24'sd32768;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT     = 1'd1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_PULL  = 2'd1,
    FUNC_FLUSH = 2'd2,
    FUNC_NOP   = 2'd3
  } ajb_func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DONE
  } ajb_state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic present;
  } ajb_cmd_t;

endpackage
`default_nettype wire

// ===== src/ajb_ram.sv =====
`default_nettype none
module ajb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== src/ajb_ctrl.sv =====
`default_nettype none
module ajb_ctrl (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output ajb_pkg::ajb_cmd_t cmd
);

  ajb_pkg::ajb_state_t state;
  ajb_pkg::ajb_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ajb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ajb_pkg::ST_IDLE: begin
        if (start) state_next = ajb_pkg::ST_EXEC;
      end
      ajb_pkg::ST_EXEC: begin
        state_next = ajb_pkg::ST_DONE;
      end
      ajb_pkg::ST_DONE: begin
        state_next = start ? ajb_pkg::ST_EXEC : ajb_pkg::ST_IDLE;
      end
      default: begin
        state_next = ajb_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ajb_pkg::ST_IDLE: begin
        cmd.load = start;
      end
      ajb_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      ajb_pkg::ST_DONE: begin
        cmd.load    = start;
        cmd.present = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== src/ajb_dp.sv =====
`default_nettype none
module ajb_dp #(
  parameter int CAPACITY = ajb_pkg::CAPACITY_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire ajb_pkg::ajb_cmd_t                 cmd,
  input  wire logic [ajb_pkg::FUNC_W-1:0]        func,
  input  wire logic [ajb_pkg::BYTE_W-1:0]        data_byte,
  input  wire logic                              cfg_write,
  input  wire logic [ajb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ajb_pkg::CFG_W-1:0]         cfg_data,
  output logic signed [ajb_pkg::SAMPLE_W-1:0]    sample_out,
  output logic                                   from_buffer,
  output logic                                   dropped,
  output logic      [ajb_pkg::FILL_W-1:0]        fill_level
);

  localparam int PW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > ajb_pkg::FILL_W) ? CW : ajb_pkg::FILL_W;
  localparam logic [PW-1:0] PTR_LAST = PW'(CAPACITY - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(CAPACITY);

  logic [ajb_pkg::FUNC_W-1:0]  func_q;
  logic [ajb_pkg::BYTE_W-1:0]  byte_q;
  logic [ajb_pkg::THR_W-1:0]   threshold;
  logic [ajb_pkg::SHIFT_W-1:0] shift;

  logic [PW-1:0] read_pointer;
  logic [PW-1:0] write_pointer;
  logic [CW-1:0] held_count;
  logic          buffering;

  logic [PW-1:0] read_pointer_next;
  logic [PW-1:0] write_pointer_next;
  logic [CW-1:0] held_count_next;
  logic          buffering_next;

  logic [ajb_pkg::BYTE_W-1:0]  rd_data;
  logic                        wr_en;
  logic                        full;
  logic                        empty;
  logic                        gate_closed;
  logic                        pop;
  logic                        drop;
  logic signed [ajb_pkg::BYTE_W-1:0]  centred;
  logic signed [ajb_pkg::SCALE_W-1:0] scaled;
  logic signed [ajb_pkg::SAMPLE_W-1:0] sample_sat;
  logic [CMPW-1:0] fill_ext;

  ajb_ram #(
    .WIDTH (ajb_pkg::BYTE_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (write_pointer),
    .wr_data (byte_q),
    .rd_en   (cmd.load),
    .rd_addr (read_pointer),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= ajb_pkg::THR_RESET;
      shift     <= ajb_pkg::SHIFT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        ajb_pkg::REG_THRESHOLD: threshold <= cfg_data;
        ajb_pkg::REG_SHIFT:     shift     <= cfg_data[ajb_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= func;
      byte_q <= data_byte;
    end
  end

  always_comb begin
    full        = (held_count == CNT_FULL);
    empty       = (held_count == '0);
    gate_closed = buffering && (CMPW'(held_count) < CMPW'(threshold));
    pop  = 1'b0;
    drop = 1'b0;
    wr_en = 1'b0;
    read_pointer_next  = read_pointer;
    write_pointer_next = write_pointer;
    held_count_next    = held_count;
    buffering_next     = buffering;
    case (ajb_pkg::ajb_func_t'(func_q))
      ajb_pkg::FUNC_PUSH: begin
        if (full) begin
          drop = 1'b1;
        end else begin
          wr_en = cmd.exec;
          write_pointer_next = (write_pointer == PTR_LAST) ? '0 : write_pointer + 1'b1;
          held_count_next    = held_count + 1'b1;
        end
      end
      ajb_pkg::FUNC_PULL: begin
        if (empty) begin
          buffering_next = 1'b1;
        end else if (!gate_closed) begin
          pop = 1'b1;
          buffering_next    = 1'b0;
          read_pointer_next = (read_pointer == PTR_LAST) ? '0 : read_pointer + 1'b1;
          held_count_next   = held_count - 1'b1;
        end
      end
      ajb_pkg::FUNC_FLUSH: begin
        read_pointer_next  = '0;
        write_pointer_next = '0;
        held_count_next    = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    centred = $signed({~rd_data[ajb_pkg::BYTE_W-1], rd_data[ajb_pkg::BYTE_W-2:0]});
    scaled  = ajb_pkg::SCALE_W'(centred) <<< shift;
    if (scaled > ajb_pkg::SAT_MAX) begin
      sample_sat = ajb_pkg::SAT_MAX[ajb_pkg::SAMPLE_W-1:0];
    end else if (scaled < ajb_pkg::SAT_MIN) begin
      sample_sat = ajb_pkg::SAT_MIN[ajb_pkg::SAMPLE_W-1:0];
    end else begin
      sample_sat = scaled[ajb_pkg::SAMPLE_W-1:0];
    end
    fill_ext = CMPW'(held_count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_pointer  <= '0;
      write_pointer <= '0;
      held_count    <= '0;
      buffering     <= 1'b1;
    end else if (cmd.exec) begin
      read_pointer  <= read_pointer_next;
      write_pointer <= write_pointer_next;
      held_count    <= held_count_next;
      buffering     <= buffering_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      sample_out  <= pop ? sample_sat : '0;
      from_buffer <= pop;
      dropped     <= drop;
      fill_level  <= fill_ext[ajb_pkg::FILL_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== src/audio_jitter_buffer_top.sv =====
// Audio jitter buffer: a ring FIFO of unsigned 8-bit samples with a
// pre-buffering gate in front of playback.
// Command channel: func (push, pull, flush, no-op) and data_byte are taken
// on a rising edge with start high and busy low.
// Result channel: done pulses for one cycle with sample_out, from_buffer,
// dropped and fill_level; exactly one result per command.
// Sequence: after the transfer edge the controller passes through EXEC, where
// the datapath registers the result, and then DONE, where done is high. A
// new command is taken in the cycle done is shown; a command has an update
// cycle, which works on the sample read at the transfer edge, and a result cycle.
// Pulls return silence while buffering and below the threshold; an
// empty pull restarts buffering. A push into a full FIFO is dropped and
// flagged. Flush clears pointers and count, not the buffering state.
// Configuration: cfg_write with cfg_index 0 (threshold) or 1 (shift).
// Reset (rst, synchronous) empties the FIFO, sets buffering, and loads
// threshold 256 and shift 7. The receiver cannot stall: each result is
// valid only in its done cycle.
`default_nettype none
module audio_jitter_buffer_top #(
  parameter int CAPACITY = ajb_pkg::CAPACITY_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [ajb_pkg::FUNC_W-1:0]        func,
  input  wire logic [ajb_pkg::BYTE_W-1:0]        data_byte,
  output logic                                   done,
  output logic signed [ajb_pkg::SAMPLE_W-1:0]    sample_out,
  output logic                                   from_buffer,
  output logic                                   dropped,
  output logic      [ajb_pkg::FILL_W-1:0]        fill_level,
  input  wire logic                              cfg_write,
  input  wire logic [ajb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ajb_pkg::CFG_W-1:0]         cfg_data
);

  ajb_pkg::ajb_cmd_t cmd;

  ajb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd)
  );

  ajb_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .func        (func),
    .data_byte   (data_byte),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sample_out  (sample_out),
    .from_buffer (from_buffer),
    .dropped     (dropped),
    .fill_level  (fill_level)
  );

  assign busy = cmd.exec;
  assign done = cmd.present;

`ifndef SYNTH
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done) ##1 done)
    else $error("result not presented two cycles after command transfer");

  a_pop_xor_drop: assert property (@(posedge clk) disable iff (rst)
    done |-> !(from_buffer && dropped))
    else $error("pop and drop flagged for one command");

  a_sample_from_buffer: assert property (@(posedge clk) disable iff (rst)
    (done && (sample_out != '0)) |-> from_buffer)
    else $error("nonzero sample without a pop");
`endif

endmodule
`default_nettype wire

// ===== verif/audio_jitter_buffer_top_tb.sv =====
`default_nettype none
module audio_jitter_buffer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ajb_pkg::*;

  localparam int CAP = CAPACITY_DEFAULT;
  localparam int MID_CODE = 128;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       from_buffer;
    logic                       dropped;
    logic [FILL_W-1:0]          fill;
  } play_result_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       start;
  logic                       busy;
  logic [FUNC_W-1:0]          func;
  logic [BYTE_W-1:0]          data_byte;
  logic                       done;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       from_buffer;
  logic                       dropped;
  logic [FILL_W-1:0]          fill_level;
  logic                       cfg_write;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_W-1:0]           cfg_data;

  audio_jitter_buffer_top u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .func        (func),
    .data_byte   (data_byte),
    .done        (done),
    .sample_out  (sample_out),
    .from_buffer (from_buffer),
    .dropped     (dropped),
    .fill_level  (fill_level),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow of the ring buffer and its gate
  logic [BYTE_W-1:0]  ring_mem [CAP];
  int                 ring_rd;
  int                 ring_wr;
  int                 ring_held;
  bit                 gate_closed;
  logic [THR_W-1:0]   cfg_threshold;
  logic [SHIFT_W-1:0] cfg_shift;

  play_result_t pending_results[$];
  int sent_count = 0;
  int logged_count = 0;
  int checked_count = 0;
  int mismatches = 0;
  int stall_cycles = 0;
  bit gaps_on = 1'b0;
  bit quiet_tail = 1'b0;

  function automatic logic signed [SAMPLE_W-1:0] scale_byte(input logic [BYTE_W-1:0] b);
    int centred;
    int scaled;
    centred = int'(b) - MID_CODE;
    scaled = centred * (1 << cfg_shift);
    if (scaled > 32767) begin
      scaled = 32767;
    end else if (scaled < -32768) begin
      scaled = -32768;
    end
    return scaled[SAMPLE_W-1:0];
  endfunction

  function automatic play_result_t ring_step(input ajb_func_t op, input logic [BYTE_W-1:0] b);
    play_result_t r;
    r = '0;
    case (op)
      FUNC_PUSH: begin
        if (ring_held >= CAP) begin
          r.dropped = 1'b1;
        end else begin
          ring_mem[ring_wr] = b;
          ring_wr = (ring_wr + 1) % CAP;
          ring_held++;
        end
      end
      FUNC_PULL: begin
        if (ring_held == 0) begin
          gate_closed = 1'b1;
        end else if (!(gate_closed && ring_held < int'(cfg_threshold))) begin
          gate_closed = 1'b0;
          r.sample = scale_byte(ring_mem[ring_rd]);
          r.from_buffer = 1'b1;
          ring_rd = (ring_rd + 1) % CAP;
          ring_held--;
        end
      end
      FUNC_FLUSH: begin
        ring_rd = 0;
        ring_wr = 0;
        ring_held = 0;
      end
      default: begin
      end
    endcase
    r.fill = ring_held[FILL_W-1:0];
    return r;
  endfunction

  function automatic void note_mismatch(input string what, input play_result_t want,
                                        input play_result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: expected sample=%0d from_buffer=%0b dropped=%0b fill=%0d",
               $realtime, what, want.sample, want.from_buffer, want.dropped, want.fill);
      $display("%0t %s:   actual sample=%0d from_buffer=%0b dropped=%0b fill=%0d",
               $realtime, what, got.sample, got.from_buffer, got.dropped, got.fill);
    end
  endfunction

  always @(posedge clk) begin
    play_result_t got;
    play_result_t want;
    if (rst) begin
      ring_rd = 0;
      ring_wr = 0;
      ring_held = 0;
      gate_closed = 1'b1;
      cfg_threshold = THR_RESET;
      cfg_shift = SHIFT_RESET;
      stall_cycles = 0;
    end else begin
      if (done) begin
        got.sample = sample_out;
        got.from_buffer = from_buffer;
        got.dropped = dropped;
        got.fill = fill_level;
        if (pending_results.size() == 0) begin
          note_mismatch("unexpected result", '0, got);
        end else begin
          want = pending_results.pop_front();
          checked_count++;
          if (got.sample != want.sample || got.from_buffer != want.from_buffer ||
              got.dropped != want.dropped || got.fill != want.fill) begin
            note_mismatch("result mismatch", want, got);
          end
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_THRESHOLD: cfg_threshold = cfg_data[THR_W-1:0];
          REG_SHIFT:     cfg_shift = cfg_data[SHIFT_W-1:0];
          default: begin
          end
        endcase
      end
      if (start && !busy) begin
        pending_results.push_back(ring_step(ajb_func_t'(func), data_byte));
        logged_count++;
      end
      if (done || (start && !busy)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("** audio_jitter_buffer_top: FAILED **");
          $finish;
        end
      end
    end
  end

  task automatic send_item(input ajb_func_t op, input logic [BYTE_W-1:0] b);
    int gap;
    if (!quiet_tail && sent_count % 48 == 0) gaps_on = ($urandom_range(0, 2) != 0);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    func <= op;
    data_byte <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_count++;
    wait (logged_count == sent_count);
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    wait (checked_count == logged_count);
    @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] shift_word);
    wait_for_results();
    cfg_write <= 1'b1;
    cfg_index <= REG_THRESHOLD;
    cfg_data <= thr;
    @(posedge clk);
    cfg_index <= REG_SHIFT;
    cfg_data <= shift_word;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic ajb_func_t pick_op(input int push_pct, input int flush_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < push_pct) return FUNC_PUSH;
    if (r < 95 - flush_pct) return FUNC_PULL;
    if (r < 100 - flush_pct) return FUNC_NOP;
    return FUNC_FLUSH;
  endfunction

  function automatic logic [CFG_W-1:0] pick_threshold();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CFG_W'(1);
      2:       return CFG_W'(CAP);
      3:       return CFG_W'($urandom_range(CAP + 1, 2047));
      default: return CFG_W'($urandom_range(2, 48));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_shift_word();
    logic [SHIFT_W-1:0] sh;
    logic [CFG_W-SHIFT_W-1:0] upper;
    sh = ($urandom_range(0, 3) == 0) ? SHIFT_W'($urandom_range(9, 15))
                                     : SHIFT_W'($urandom_range(0, 8));
    upper = ($urandom_range(0, 1) == 0) ? '0 : (CFG_W-SHIFT_W)'($urandom);
    return {upper, sh};
  endfunction

  task automatic test_reset_defaults();
    send_item(FUNC_PULL, 8'h00);
    send_item(FUNC_PUSH, 8'h00);
    send_item(FUNC_PULL, 8'hff);
    send_item(FUNC_NOP, 8'hff);
    send_item(FUNC_FLUSH, 8'h5a);
  endtask

  task automatic test_zero_threshold();
    set_config(CFG_W'(0), CFG_W'(0));
    send_item(FUNC_PULL, 8'h00);
    send_item(FUNC_PUSH, 8'hff);
    send_item(FUNC_PUSH, 8'h01);
    send_item(FUNC_PULL, 8'h00);
    send_item(FUNC_PULL, 8'h00);
    send_item(FUNC_PULL, 8'h00);
  endtask

  task automatic test_gate_threshold();
    set_config(CFG_W'(3), CFG_W'(8));
    send_item(FUNC_PUSH, 8'h00);
    send_item(FUNC_PUSH, 8'h80);
    send_item(FUNC_PULL, 8'h00);
    send_item(FUNC_PUSH, 8'hff);
    repeat (4) send_item(FUNC_PULL, 8'h00);
  endtask

  task automatic test_saturation();
    set_config(CFG_W'(1), 11'h7ff);
    send_item(FUNC_PUSH, 8'hff);
    send_item(FUNC_PUSH, 8'h00);
    send_item(FUNC_PUSH, 8'h7f);
    repeat (3) send_item(FUNC_PULL, 8'h00);
  endtask

  task automatic test_closed_gate();
    set_config(11'h7ff, {7'h55, 4'h9});
    send_item(FUNC_PUSH, 8'haa);
    send_item(FUNC_PULL, 8'h00);
    send_item(FUNC_PULL, 8'h00);
    send_item(FUNC_PUSH, 8'h55);
    send_item(FUNC_PULL, 8'h00);
    send_item(FUNC_FLUSH, 8'h00);
    send_item(FUNC_PULL, 8'h00);
  endtask

  task automatic test_overflow();
    set_config(CFG_W'(CAP), CFG_W'($urandom_range(0, 8)));
    while (ring_held < CAP) send_item(pick_op(90, 0), BYTE_W'($urandom));
    repeat (6) send_item(FUNC_PUSH, BYTE_W'($urandom));
    send_item(FUNC_PULL, BYTE_W'($urandom));
    send_item(FUNC_PUSH, BYTE_W'($urandom));
    send_item(FUNC_PUSH, BYTE_W'($urandom));
    repeat (60) send_item(pick_op(20, 0), BYTE_W'($urandom));
    send_item(FUNC_FLUSH, BYTE_W'($urandom));
    send_item(FUNC_PULL, BYTE_W'($urandom));
  endtask

  task automatic test_random_mix();
    int push_pct;
    repeat (5) begin
      set_config(pick_threshold(), pick_shift_word());
      push_pct = $urandom_range(35, 65);
      repeat ($urandom_range(60, 120)) begin
        if ($urandom_range(0, 79) == 0) wait_for_results();
        send_item(pick_op(push_pct, 2), BYTE_W'($urandom));
      end
    end
  endtask

  task automatic test_back_to_back();
    quiet_tail = 1'b1;
    gaps_on = 1'b0;
    set_config(CFG_W'($urandom_range(0, 8)), CFG_W'($urandom_range(0, 8)));
    repeat (100) send_item(pick_op(50, 1), BYTE_W'($urandom));
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    func <= FUNC_NOP;
    data_byte <= '0;
    cfg_write <= 1'b0;
    cfg_index <= REG_THRESHOLD;
    cfg_data <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_zero_threshold();
    test_gate_threshold();
    test_saturation();
    test_closed_gate();
    test_overflow();
    test_random_mix();
    test_back_to_back();

    start <= 1'b0;
    wait (checked_count == logged_count);
    repeat (16) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("** audio_jitter_buffer_top: PASSED **");
    end else begin
      $display("** audio_jitter_buffer_top: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
